/* rtl/core/pcw_pkg.sv */
// Package with the shared types and constants of the PNG chunk walker.
package pcw_pkg;

   // Input transaction: one byte of the file and the start-of-file mark.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } req_payload_type;

   // Result transaction: a chunk header or the image header.
   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] type_code;
      logic [31:0] data_length;
      logic [31:0] total_length;
      logic        is_ancillary;
      logic        is_private;
      logic        reserved_set;
      logic        length_too_big;
      logic [15:0] chunk_index;
      logic [31:0] image_width;
      logic [31:0] image_height;
      logic [39:0] header_params;
   } rsp_payload_type;

   // Result kinds.
   localparam logic [1:0] KIND_CHUNK     = 2'd0;
   localparam logic [1:0] KIND_FINAL     = 2'd1;
   localparam logic [1:0] KIND_IMAGE_HDR = 2'd2;

   // File layout.
   localparam logic [31:0] SIG_BYTES      = 32'd8;
   localparam logic [31:0] CHUNK_OVERHEAD = 32'd12;
   localparam logic [31:0] CRC_BYTES      = 32'd4;
   localparam logic [4:0]  WIDTH_FIRST    = 5'd16;
   localparam logic [4:0]  WIDTH_LAST     = 5'd19;
   localparam logic [4:0]  HEIGHT_FIRST   = 5'd20;
   localparam logic [4:0]  HEIGHT_LAST    = 5'd23;
   localparam logic [4:0]  PARAMS_FIRST   = 5'd24;
   localparam logic [4:0]  HDR_LAST_BYTE  = 5'd28;
   localparam logic [4:0]  OFFSET_SAT     = 5'd29;
   localparam logic [2:0]  HDR_POS_LAST   = 3'd7;
   localparam logic [2:0]  HDR_POS_TYPE   = 3'd4;

   // Chunk type "IEND".
   localparam logic [31:0] TYPE_IEND = 32'h49454E44;

endpackage

/* rtl/core/pcw_stream_if.sv */
// Valid/ready stream interface that carries one payload per transaction.
interface pcw_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/png_chunk_walker_unit.sv */
// Top level of the PNG chunk walker: byte parser, chunk and image-header reports.
// A result is registered in the result register, or in the skid register while
// the sink stalls, before it appears on rsp_if. Throughput: one byte per cycle
// while the skid register is free; the two-entry output buffer (result register
// plus skid register) lets bytes flow while one result waits on a stalled sink.
// Reset (synchronous, active high) empties the output buffer and leaves the walk
// stopped, so bytes are ignored until one arrives with file_start set.
module png_chunk_walker_unit #(
   parameter int CHUNK_INDEX_BITS = 16
) (
   input logic               clock,
   input logic               reset,
   pcw_stream_if.sink        req_if,
   pcw_stream_if.source      rsp_if
);

   // ------------------------------------------------------------------
   // Walk state. Every register has its next value in the matching _in.
   // ------------------------------------------------------------------
   logic [4:0]                  file_offset_ff, file_offset_in;
   logic [2:0]                  header_pos_ff,  header_pos_in;
   logic [31:0]                 skip_count_ff,  skip_count_in;
   logic [31:0]                 length_acc_ff,  length_acc_in;
   logic [31:0]                 type_acc_ff,    type_acc_in;
   logic [CHUNK_INDEX_BITS-1:0] chunk_count_ff, chunk_count_in;
   logic [31:0]                 width_acc_ff,   width_acc_in;
   logic [31:0]                 height_acc_ff,  height_acc_in;
   logic [39:0]                 params_acc_ff,  params_acc_in;
   logic                        walk_done_ff,   walk_done_in;

   // Output buffer: result register and skid register.
   logic                        out_valid_ff,  out_valid_in;
   pcw_pkg::rsp_payload_type    out_data_ff,   out_data_in;
   logic                        skid_valid_ff, skid_valid_in;
   pcw_pkg::rsp_payload_type    skid_data_ff,  skid_data_in;

   // Working copies of the state after a file start has been applied.
   logic [4:0]                  cur_offset;
   logic [2:0]                  cur_pos;
   logic [31:0]                 cur_skip;
   logic [31:0]                 cur_length;
   logic [31:0]                 cur_type;
   logic [CHUNK_INDEX_BITS-1:0] cur_count;
   logic [31:0]                 cur_width;
   logic [31:0]                 cur_height;
   logic [39:0]                 cur_params;

   logic [7:0]                  byte_in;
   logic                        req_fire;
   logic                        out_take;
   logic                        step_active;
   logic                        chunk_ready;
   logic                        image_ready;
   logic                        has_result;
   logic [31:0]                 full_length;
   logic [31:0]                 full_type;
   logic                        too_big;
   logic                        is_end;
   logic [CHUNK_INDEX_BITS-1:0] count_next;
   logic [31:0]                 count_wide;
   pcw_pkg::rsp_payload_type    result;

   // A new byte is taken whenever the skid register is free, so a result that
   // waits in the result register never blocks the input side.
   assign req_if.ready = !skid_valid_ff;
   assign req_fire     = req_if.valid && req_if.ready;
   assign out_take     = out_valid_ff && rsp_if.ready;
   assign byte_in      = req_if.payload.data_byte;

   // A byte does work when it starts a file or the walk is still running.
   assign step_active = req_if.payload.file_start || !walk_done_ff;

   // ------------------------------------------------------------------
   // Next walk state for one byte.
   // ------------------------------------------------------------------
   always_comb begin
      // A file start clears the walk and arms the signature skip first.
      if (req_if.payload.file_start) begin
         cur_offset = '0;
         cur_pos    = '0;
         cur_skip   = pcw_pkg::SIG_BYTES;
         cur_length = '0;
         cur_type   = '0;
         cur_count  = '0;
         cur_width  = '0;
         cur_height = '0;
         cur_params = '0;
      end else begin
         cur_offset = file_offset_ff;
         cur_pos    = header_pos_ff;
         cur_skip   = skip_count_ff;
         cur_length = length_acc_ff;
         cur_type   = type_acc_ff;
         cur_count  = chunk_count_ff;
         cur_width  = width_acc_ff;
         cur_height = height_acc_ff;
         cur_params = params_acc_ff;
      end

      file_offset_in = file_offset_ff;
      header_pos_in  = header_pos_ff;
      skip_count_in  = skip_count_ff;
      length_acc_in  = length_acc_ff;
      type_acc_in    = type_acc_ff;
      chunk_count_in = chunk_count_ff;
      width_acc_in   = width_acc_ff;
      height_acc_in  = height_acc_ff;
      params_acc_in  = params_acc_ff;
      walk_done_in   = walk_done_ff;

      // The length field is complete once the type bytes start, so the last
      // header byte always lands in the type accumulator.
      full_length = cur_length;
      full_type   = {cur_type[23:0], byte_in};
      too_big     = full_length[31];
      is_end      = (full_type == pcw_pkg::TYPE_IEND);
      count_next  = (&cur_count) ? cur_count : cur_count + CHUNK_INDEX_BITS'(1);

      chunk_ready = step_active && (cur_skip == '0) && (cur_pos == pcw_pkg::HDR_POS_LAST);
      image_ready = step_active && (cur_offset == pcw_pkg::HDR_LAST_BYTE);

      if (req_fire && step_active) begin
         walk_done_in   = 1'b0;
         file_offset_in = (cur_offset < pcw_pkg::OFFSET_SAT) ? cur_offset + 5'd1 : cur_offset;

         // Image-header fields sit at fixed file offsets.
         width_acc_in  = cur_width;
         height_acc_in = cur_height;
         params_acc_in = cur_params;
         if (cur_offset >= pcw_pkg::WIDTH_FIRST && cur_offset <= pcw_pkg::WIDTH_LAST) begin
            width_acc_in = {cur_width[23:0], byte_in};
         end else if (cur_offset >= pcw_pkg::HEIGHT_FIRST &&
                      cur_offset <= pcw_pkg::HEIGHT_LAST) begin
            height_acc_in = {cur_height[23:0], byte_in};
         end else if (cur_offset >= pcw_pkg::PARAMS_FIRST &&
                      cur_offset <= pcw_pkg::HDR_LAST_BYTE) begin
            params_acc_in = {cur_params[31:0], byte_in};
         end

         chunk_count_in = cur_count;
         header_pos_in  = cur_pos;
         length_acc_in  = cur_length;
         type_acc_in    = cur_type;
         skip_count_in  = cur_skip;

         if (cur_skip != '0) begin
            // Signature, chunk data or CRC byte.
            skip_count_in = cur_skip - 32'd1;
         end else if (chunk_ready) begin
            // Last type byte: the chunk header is complete.
            chunk_count_in = count_next;
            header_pos_in  = '0;
            length_acc_in  = '0;
            type_acc_in    = '0;
            if (too_big || is_end) begin
               walk_done_in = 1'b1;
            end else begin
               skip_count_in = full_length + pcw_pkg::CRC_BYTES;
            end
         end else begin
            header_pos_in = cur_pos + 3'd1;
            if (cur_pos < pcw_pkg::HDR_POS_TYPE) begin
               length_acc_in = {cur_length[23:0], byte_in};
            end else begin
               type_acc_in = {cur_type[23:0], byte_in};
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result formatting. A chunk report wins over the image header when
   // both complete on the same byte.
   // ------------------------------------------------------------------
   assign count_wide = 32'(count_next);

   always_comb begin
      result = '0;
      if (chunk_ready) begin
         result.result_kind    = (too_big || is_end) ? pcw_pkg::KIND_FINAL
                                                     : pcw_pkg::KIND_CHUNK;
         result.type_code      = full_type;
         result.data_length    = full_length;
         result.total_length   = too_big ? '0 : full_length + pcw_pkg::CHUNK_OVERHEAD;
         result.is_ancillary   = full_type[29];
         result.is_private     = full_type[21];
         result.reserved_set   = full_type[13];
         result.length_too_big = too_big;
         result.chunk_index    = count_wide[15:0];
      end else if (image_ready) begin
         result.result_kind   = pcw_pkg::KIND_IMAGE_HDR;
         result.image_width   = width_acc_in;
         result.image_height  = height_acc_in;
         result.header_params = params_acc_in;
      end
   end

   assign has_result = req_fire && (chunk_ready || image_ready);

   // ------------------------------------------------------------------
   // Output buffer. Results leave in the order they were made: the skid
   // register only fills while the result register is occupied and stalled.
   // ------------------------------------------------------------------
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // Input is stalled here, so only a drain can happen.
         if (out_take) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_in = has_result;
         if (has_result) begin
            out_data_in = result;
         end
      end else if (has_result) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_offset_ff <= '0;
         header_pos_ff  <= '0;
         skip_count_ff  <= '0;
         length_acc_ff  <= '0;
         type_acc_ff    <= '0;
         chunk_count_ff <= '0;
         width_acc_ff   <= '0;
         height_acc_ff  <= '0;
         params_acc_ff  <= '0;
         walk_done_ff   <= 1'b1;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         file_offset_ff <= file_offset_in;
         header_pos_ff  <= header_pos_in;
         skip_count_ff  <= skip_count_in;
         length_acc_ff  <= length_acc_in;
         type_acc_ff    <= type_acc_in;
         chunk_count_ff <= chunk_count_in;
         width_acc_ff   <= width_acc_in;
         height_acc_ff  <= height_acc_in;
         params_acc_ff  <= params_acc_in;
         walk_done_ff   <= walk_done_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef SYNTH
   // The skid register only holds a result behind an occupied result register.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while result register is empty");

   // A file start always leaves the walk running.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_if.payload.file_start) |=> !walk_done_ff)
      else $error("walk stopped right after a file start");

   // Header bytes are only gathered when nothing remains to be skipped.
   assert property (@(posedge clock) disable iff (reset)
      (header_pos_ff != 3'd0) |-> (skip_count_ff == 32'd0))
      else $error("header position advanced during a skip");

   // The file offset saturates.
   assert property (@(posedge clock) disable iff (reset)
      file_offset_ff <= pcw_pkg::OFFSET_SAT)
      else $error("file offset beyond saturation");
`endif

endmodule

/* bench/tb.sv */
// Self-checking testbench for the PNG chunk walker: byte stimulus, result mirror, checks.
`timescale 1ns / 1ps

module tb;

   // The block is built with its default chunk counter width, and the mirror
   // below saturates its own count at the same top value.
   localparam int INDEX_BITS = 16;

   // Cycles in which no transaction moves on either channel before the run is
   // called hung. In a correct run, idle stretches come only from a random sender
   // gap plus a random receiver stall.
   localparam int WATCHDOG_LIMIT = 2000;

   // Cycles allowed for the last result to come out once nothing is expected.
   localparam int TAIL_CYCLES = 10;

   // Empty chunks sent in one file with idling off, so that bytes and results
   // move back to back.
   localparam int BURST_CHUNKS = 8;

   // Counted random bytes after the directed files; together they give
   // roughly 1950 input transactions.
   localparam int RANDOM_BYTES = 1530;

   // Mirror of the walker. It follows every accepted byte the same way the
   // block must, and queues the report that each byte should produce.
   class chunk_walk_mirror;
      logic [4:0]               file_offset;
      logic [2:0]               header_pos;
      logic [31:0]              skip_count;
      logic [31:0]              length_acc;
      logic [31:0]              type_acc;
      logic [31:0]              chunk_count;
      logic [31:0]              width_acc;
      logic [31:0]              height_acc;
      logic [39:0]              params_acc;
      bit                       walk_done;
      pcw_pkg::rsp_payload_type expected_reports[$];
      int                       error_count;

      function new();
         clear_walk();
         walk_done   = 1'b1;
         error_count = 0;
      endfunction

      function void clear_walk();
         file_offset = '0;
         header_pos  = '0;
         skip_count  = '0;
         length_acc  = '0;
         type_acc    = '0;
         chunk_count = '0;
         width_acc   = '0;
         height_acc  = '0;
         params_acc  = '0;
      endfunction

      function int outstanding();
         return expected_reports.size();
      endfunction

      function void note_byte(logic [7:0] b, logic start);
         logic [4:0]               off;
         logic                     too_big;
         logic                     last_chunk;
         pcw_pkg::rsp_payload_type rep;
         if (start) begin
            clear_walk();
            skip_count = pcw_pkg::SIG_BYTES;
            walk_done  = 1'b0;
         end else if (walk_done) begin
            return;
         end
         off = file_offset;
         if (file_offset < pcw_pkg::OFFSET_SAT) file_offset = file_offset + 5'd1;

         // The image-header bytes are gathered by file position alone.
         if (off >= pcw_pkg::WIDTH_FIRST && off <= pcw_pkg::WIDTH_LAST) begin
            width_acc = {width_acc[23:0], b};
         end else if (off >= pcw_pkg::HEIGHT_FIRST && off <= pcw_pkg::HEIGHT_LAST) begin
            height_acc = {height_acc[23:0], b};
         end else if (off >= pcw_pkg::PARAMS_FIRST && off <= pcw_pkg::HDR_LAST_BYTE) begin
            params_acc = {params_acc[31:0], b};
         end

         rep = '0;
         if (skip_count != 0) begin
            skip_count = skip_count - 32'd1;
         end else begin
            if (header_pos < pcw_pkg::HDR_POS_TYPE) length_acc = {length_acc[23:0], b};
            else type_acc = {type_acc[23:0], b};
            header_pos = header_pos + 3'd1;
            if (header_pos == 3'd0) begin
               // A chunk header is complete. It wins over the image header
               // when both complete on the same byte.
               too_big    = length_acc[31];
               last_chunk = too_big || (type_acc == pcw_pkg::TYPE_IEND);
               if ({32'd0, chunk_count} < ((64'd1 << INDEX_BITS) - 64'd1)) begin
                  chunk_count = chunk_count + 32'd1;
               end
               rep.result_kind    = last_chunk ? pcw_pkg::KIND_FINAL : pcw_pkg::KIND_CHUNK;
               rep.type_code      = type_acc;
               rep.data_length    = length_acc;
               rep.total_length   = too_big ? 32'd0 : length_acc + pcw_pkg::CHUNK_OVERHEAD;
               rep.is_ancillary   = type_acc[29];
               rep.is_private     = type_acc[21];
               rep.reserved_set   = type_acc[13];
               rep.length_too_big = too_big;
               rep.chunk_index    = chunk_count[15:0];
               if (last_chunk) walk_done = 1'b1;
               else skip_count = length_acc + pcw_pkg::CRC_BYTES;
               length_acc = '0;
               type_acc   = '0;
               expected_reports.push_back(rep);
               return;
            end
         end

         if (off == pcw_pkg::HDR_LAST_BYTE) begin
            rep.result_kind   = pcw_pkg::KIND_IMAGE_HDR;
            rep.image_width   = width_acc;
            rep.image_height  = height_acc;
            rep.header_params = params_acc;
            expected_reports.push_back(rep);
         end
      endfunction

      function void compare_field(string field, logic [39:0] want, logic [39:0] got);
         if (got !== want) begin
            $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, field, want, got);
            error_count++;
         end
      endfunction

      function void check_report(pcw_pkg::rsp_payload_type got);
         pcw_pkg::rsp_payload_type want;
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %0h", $time, got);
            error_count++;
            return;
         end
         want = expected_reports.pop_front();
         compare_field("result_kind", 40'(want.result_kind), 40'(got.result_kind));
         compare_field("type_code", 40'(want.type_code), 40'(got.type_code));
         compare_field("data_length", 40'(want.data_length), 40'(got.data_length));
         compare_field("total_length", 40'(want.total_length), 40'(got.total_length));
         compare_field("is_ancillary", 40'(want.is_ancillary), 40'(got.is_ancillary));
         compare_field("is_private", 40'(want.is_private), 40'(got.is_private));
         compare_field("reserved_set", 40'(want.reserved_set), 40'(got.reserved_set));
         compare_field("length_too_big", 40'(want.length_too_big),
                       40'(got.length_too_big));
         compare_field("chunk_index", 40'(want.chunk_index), 40'(got.chunk_index));
         compare_field("image_width", 40'(want.image_width), 40'(got.image_width));
         compare_field("image_height", 40'(want.image_height), 40'(got.image_height));
         compare_field("header_params", want.header_params, got.header_params);
      endfunction

      // Any report still queued at the end of the run never arrived.
      function void flag_missing();
         foreach (expected_reports[i]) begin
            $display("%0t: missing result: expected %0h, actual none", $time,
                     expected_reports[i]);
            error_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   idle_on = 1'b1;
   int   quiet_cycles = 0;
   int   counted_bytes = 0;

   chunk_walk_mirror walk_mirror = new();

   pcw_stream_if #(.payload_type(pcw_pkg::req_payload_type)) req_if ();
   pcw_stream_if #(.payload_type(pcw_pkg::rsp_payload_type)) rsp_if ();

   png_chunk_walker_unit #(
      .CHUNK_INDEX_BITS(INDEX_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #4 clock = ~clock;

   // Both channels are sampled at the rising edge, where every value seen is
   // the one from before the edge. A result can never come from the byte
   // accepted at the same edge, so the result is checked before the byte is
   // noted. The watchdog counts edges at which no transaction moves.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) walk_mirror.check_report(rsp_if.payload);
         if (req_if.valid && req_if.ready) begin
            walk_mirror.note_byte(req_if.payload.data_byte, req_if.payload.file_start);
         end
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Result receiver: before each result it stalls for a random number of
   // cycles, unless idling is switched off for the current stretch. Ready is
   // changed at most once per edge.
   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = idle_on ? $urandom_range(0, 19) : 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // Sends one byte after a random gap. Valid is lowered only when a gap is
   // drawn, so back-to-back bytes keep it high without a glitch.
   task automatic send_byte(input logic [7:0] b, input logic start);
      int gap;
      gap = idle_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= '{data_byte: b, file_start: start};
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8], 1'b0);
   endtask

   task automatic send_random_bytes(input int n);
      repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   // The first byte carries the file start mark; the signature content itself
   // is never checked by the block.
   task automatic send_signature(input logic [63:0] sig);
      send_byte(sig[63:56], 1'b1);
      for (int i = 6; i >= 0; i--) send_byte(sig[8*i +: 8], 1'b0);
   endtask

   // A complete chunk: header, data of random content and a random CRC.
   task automatic send_chunk(input logic [31:0] len, input logic [31:0] tag);
      send_word(len);
      send_word(tag);
      send_random_bytes(len);
      send_word($urandom);
   endtask

   // An IHDR chunk placed right after the signature, so that its data lands
   // on the image-header file positions.
   task automatic send_ihdr(input logic [31:0] w, input logic [31:0] h,
                            input logic [39:0] params);
      send_word(32'd13);
      send_word("IHDR");
      send_word(w);
      send_word(h);
      for (int i = 4; i >= 0; i--) send_byte(params[8*i +: 8], 1'b0);
      send_word($urandom);
   endtask

   // Pause the sender until every expected result has been received.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (walk_mirror.outstanding() > 0);
   endtask

   function automatic logic [31:0] letter_tag();
      logic [31:0] tag;
      for (int i = 0; i < 4; i++) begin
         tag[8*i +: 8] = 8'(8'h41 + $urandom_range(0, 25) + ($urandom_range(0, 1) << 5));
      end
      return tag;
   endfunction

   // One random file: mostly well formed chunk chains with random content,
   // ending in IEND, an oversized length, a huge but legal length cut short
   // by the next file, or a header that is simply truncated. Bytes sent after
   // the walk has stopped are ignored by the block and are not counted.
   task automatic send_random_file();
      int          n_chunks;
      int          len;
      int          ending;
      logic [31:0] tag;
      send_signature({$urandom, $urandom});
      counted_bytes += 8;
      n_chunks = $urandom_range(0, 5);
      for (int c = 0; c < n_chunks; c++) begin
         if (c == 0 && $urandom_range(0, 2) == 0) begin
            send_ihdr($urandom, $urandom, {8'($urandom_range(0, 255)), $urandom});
            counted_bytes += 25;
         end else begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(0, 24);
            tag = ($urandom_range(0, 5) == 0) ? $urandom : letter_tag();
            send_chunk(len, tag);
            counted_bytes += 12 + len;
         end
      end
      ending = $urandom_range(0, 9);
      if (ending <= 5) begin
         len = $urandom_range(0, 8);
         send_word(len);
         send_word(pcw_pkg::TYPE_IEND);
         counted_bytes += 8;
         send_random_bytes($urandom_range(0, 4));
      end else if (ending == 6) begin
         send_word($urandom | 32'h8000_0000);
         send_word(($urandom_range(0, 3) == 0) ? pcw_pkg::TYPE_IEND : letter_tag());
         counted_bytes += 8;
         send_random_bytes($urandom_range(0, 4));
      end else if (ending == 7) begin
         len = $urandom_range(0, 12);
         send_word(($urandom & 32'h7FFF_FFFF) | 32'h0001_0000);
         send_word(letter_tag());
         send_random_bytes(len);
         counted_bytes += 8 + len;
      end else begin
         len = $urandom_range(0, 7);
         send_random_bytes(len);
         counted_bytes += len;
      end
   endtask

   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Bytes before any file start are ignored.
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);

      // A regular file: image header with extreme fields, chunks with all
      // three flag bits set, all clear, all type bits set, then IEND with a
      // nonzero length, after which trailing bytes are ignored.
      send_signature(64'h89504E470D0A1A0A);
      send_ihdr(32'hFFFF_FFFF, 32'h0000_0000, 40'hFF_00A5_5AFF);
      send_chunk(32'd0, "zzzz");
      send_chunk(32'd3, 32'h0000_0000);
      send_chunk(32'd0, 32'hFFFF_FFFF);
      send_word(32'd7);
      send_word(pcw_pkg::TYPE_IEND);
      send_random_bytes(3);

      // A one-byte first chunk makes the next header complete on file byte
      // 28, where the chunk report replaces the image-header report.
      send_signature(64'h89504E470D0A1A0A);
      send_chunk(32'd1, "IHDR");
      send_chunk(32'd0, "IDAT");
      send_word(32'd0);
      send_word(pcw_pkg::TYPE_IEND);

      // An all-ones length stops the walk before the image-header bytes, so
      // no image-header report follows.
      send_signature(64'h89504E470D0A1A0A);
      send_word(32'hFFFF_FFFF);
      send_word("IDAT");
      send_random_bytes(16);

      // An IEND whose length is also too big.
      send_signature(64'h89504E470D0A1A0A);
      send_ihdr(32'h0000_0001, 32'hFFFF_FFFF, 40'h00_FF5A_A500);
      send_word(32'h8000_0000);
      send_word(pcw_pkg::TYPE_IEND);

      // The largest legal length, then a restart in the middle of its data.
      send_signature(64'h89504E470D0A1A0A);
      send_word(32'h7FFF_FFFF);
      send_word("bIGg");
      send_random_bytes(5);
      send_signature(64'h0);
      send_chunk(32'd0, "IEND");

      // Back-to-back file starts, then a restart in the middle of a header.
      send_byte(8'h89, 1'b1);
      send_byte(8'h89, 1'b1);
      send_signature(64'h89504E470D0A1A0A);
      send_random_bytes(5);
      send_signature(64'h89504E470D0A1A0A);
      send_ihdr($urandom, $urandom, 40'h08_0200_0001);
      send_chunk(32'd0, pcw_pkg::TYPE_IEND);

      drain_results();

      // A run of empty chunks with idling off, so that bytes are taken in
      // every cycle and results are drained as fast as they are made.
      idle_on = 1'b0;
      send_signature(64'h89504E470D0A1A0A);
      for (int i = 0; i < BURST_CHUNKS; i++) begin
         send_word(32'd0);
         send_word("sPAm");
         send_word(32'd0);
      end
      send_word(32'd0);
      send_word(pcw_pkg::TYPE_IEND);
      drain_results();

      // Random files, with idling switched on for most of them and now and
      // then a pause until the block has delivered everything.
      while (counted_bytes < RANDOM_BYTES) begin
         idle_on = ($urandom_range(0, 4) != 0);
         send_random_file();
         if ($urandom_range(0, 9) == 0) drain_results();
      end

      req_if.valid <= 1'b0;
      do @(posedge clock); while (walk_mirror.outstanding() > 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      walk_mirror.flag_missing();
      if (walk_mirror.error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
